@@ hw/rtl/wav_pcm16_mono_stream_parser_unit_defines.svh @@
// Assertion macros for the WAVE stream parser.
// Included by the top level, which supplies the clock and the active-low reset.
`ifndef WAV_PCM16_MONO_STREAM_PARSER_UNIT_DEFINES_SVH
`define WAV_PCM16_MONO_STREAM_PARSER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WAVP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WAVP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/wavp_pkg.sv @@
// Shared types, codes and constants for the WAVE stream parser.
// Has no dependencies; the top level refers to it by scoped names.
`default_nettype none

package wavp_pkg;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_SMALL     = 4'd1,
    ST_TAG       = 4'd2,
    ST_OVERRUN   = 4'd3,
    ST_FMT_SMALL = 4'd4,
    ST_MISSING   = 4'd5,
    ST_NOT_PCM   = 4'd6,
    ST_NOT_MONO  = 4'd7,
    ST_NOT_16BIT = 4'd8,
    ST_RATE      = 4'd9,
    ST_DATA_SIZE = 4'd10,
    ST_TWO_DATA  = 4'd11
  } status_t;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_FMT   = 2'd1,
    KIND_DATA  = 2'd2
  } chunk_kind_t;

  typedef enum logic {
    RK_SAMPLE = 1'b0,
    RK_STATUS = 1'b1
  } result_kind_t;

  typedef struct packed {
    result_kind_t kind;
    logic [15:0]  sample;
    status_t      status;
    logic [30:0]  rate;
    logic         end_of_run;
  } result_t;

  localparam logic [31:0] ID_FMT        = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA       = 32'h6174_6164;
  localparam logic [31:0] FMT_MIN_SIZE  = 32'd16;
  localparam logic [3:0]  HDR_LEN       = 4'd12;
  localparam logic [4:0]  FMT_FIELD_END = 5'd16;

  // Result queue depth; a power of two so that the pointers wrap naturally.
  localparam int QUEUE_DEPTH = 4;

  function automatic logic tag_checked(input logic [3:0] pos);
    tag_checked = (pos < 4'd4) || (pos >= 4'd8);
  endfunction

  function automatic logic [7:0] tag_byte(input logic [3:0] pos);
    unique case (pos)
      4'd0:    tag_byte = 8'h52;
      4'd1:    tag_byte = 8'h49;
      4'd2:    tag_byte = 8'h46;
      4'd3:    tag_byte = 8'h46;
      4'd8:    tag_byte = 8'h57;
      4'd9:    tag_byte = 8'h41;
      4'd10:   tag_byte = 8'h56;
      4'd11:   tag_byte = 8'h45;
      default: tag_byte = 8'h00;
    endcase
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/wav_pcm16_mono_stream_parser_unit.sv @@
// A byte is held in the input register on acceptance and its results are written from there
// into the result queue once it has room for two; the queue head drives the outputs.
// Throughput: one byte per cycle while the four-entry result queue keeps room for
// two results; a byte that yields a sample and the status needs two output words.
// Reset: synchronous, active low; clears the parser state and empties the queue.
// Depends on wavp_pkg and the assertion macros in wav_pcm16_mono_stream_parser_unit_defines.svh.
`default_nettype none
`include "wav_pcm16_mono_stream_parser_unit_defines.svh"

module wav_pcm16_mono_stream_parser_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic [7:0]         in_file_byte,
  input  wire logic               in_final_byte,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic               out_result_kind,
  output      logic signed [15:0] out_sample_value,
  output      logic [3:0]         out_status_code,
  output      logic [30:0]        out_sample_rate,
  output      logic               out_end_of_run
);

  localparam int QDEPTH = wavp_pkg::QUEUE_DEPTH;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam logic [QCNT_W-1:0] QROOM = QCNT_W'(QDEPTH - 2);

  // Input register.
  logic       s1_vld_r;
  logic [7:0] s1_byte_r;
  logic       s1_fin_r;
  logic       go;

  // Parser state.
  logic [3:0]            hp_r, hp_nxt;
  logic                  tag_bad_r, tag_bad_nxt;
  logic [55:0]           shift_r, shift_nxt;
  logic [2:0]            hcnt_r, hcnt_nxt;
  logic [31:0]           left_r, left_nxt;
  wavp_pkg::chunk_kind_t kind_r, kind_nxt;
  logic                  pad_r, pad_nxt;
  logic [4:0]            fofs_r, fofs_nxt;
  logic [31:0]           rate_r, rate_nxt;
  logic                  fmt_ok_r, fmt_ok_nxt;
  logic                  chan_ok_r, chan_ok_nxt;
  logic                  bits_ok_r, bits_ok_nxt;
  logic                  small_r, small_nxt;
  logic                  have_fmt_r, have_fmt_nxt;
  logic [1:0]            dcnt_r, dcnt_nxt;
  logic [31:0]           dlen_r, dlen_nxt;
  logic                  hold_vld_r, hold_vld_nxt;
  logic [7:0]            hold_r, hold_nxt;
  wavp_pkg::status_t     err_r, err_nxt;

  logic [31:0]       hdr_id;
  logic [31:0]       hdr_size;
  logic              empty_body;
  wavp_pkg::status_t st;

  logic              smp_push;
  logic [15:0]       smp_val;
  logic              stat_push;
  wavp_pkg::result_t smp_res;
  wavp_pkg::result_t stat_res;

  // Result queue.
  wavp_pkg::result_t q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] qcnt_r, qcnt_nxt;
  logic [QPTR_W-1:0] stat_addr;
  logic              pop;
  wavp_pkg::result_t head;

  assign go       = s1_vld_r && (qcnt_r <= QROOM);
  assign in_stall = s1_vld_r && !go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_byte_r <= in_file_byte;
      s1_fin_r  <= in_final_byte;
    end
  end

  always_comb begin
    hp_nxt       = hp_r;
    tag_bad_nxt  = tag_bad_r;
    shift_nxt    = shift_r;
    hcnt_nxt     = hcnt_r;
    left_nxt     = left_r;
    kind_nxt     = kind_r;
    pad_nxt      = pad_r;
    fofs_nxt     = fofs_r;
    rate_nxt     = rate_r;
    fmt_ok_nxt   = fmt_ok_r;
    chan_ok_nxt  = chan_ok_r;
    bits_ok_nxt  = bits_ok_r;
    small_nxt    = small_r;
    have_fmt_nxt = have_fmt_r;
    dcnt_nxt     = dcnt_r;
    dlen_nxt     = dlen_r;
    hold_vld_nxt = hold_vld_r;
    hold_nxt     = hold_r;
    err_nxt      = err_r;
    hdr_id       = shift_r[31:0];
    hdr_size     = {s1_byte_r, shift_r[55:32]};
    empty_body   = 1'b0;
    st           = wavp_pkg::ST_OK;
    smp_push     = 1'b0;
    smp_val      = {s1_byte_r, hold_r};
    stat_push    = 1'b0;

    if (go) begin
      if (hp_r < wavp_pkg::HDR_LEN) begin
        if (wavp_pkg::tag_checked(hp_r) && (s1_byte_r != wavp_pkg::tag_byte(hp_r))) begin
          tag_bad_nxt = 1'b1;
        end
        hp_nxt = hp_r + 4'd1;
        if (hp_nxt == wavp_pkg::HDR_LEN) begin
          if (tag_bad_nxt) begin
            err_nxt = wavp_pkg::ST_TAG;
          end
          tag_bad_nxt = 1'b0;
        end
      end else if (err_r == wavp_pkg::ST_OK) begin
        if (left_r != 32'd0) begin
          if (kind_r == wavp_pkg::KIND_FMT) begin
            if (fofs_r < wavp_pkg::FMT_FIELD_END) begin
              unique case (fofs_r)
                5'd0:    fmt_ok_nxt  = (s1_byte_r == 8'd1);
                5'd1:    fmt_ok_nxt  = fmt_ok_r && (s1_byte_r == 8'd0);
                5'd2:    chan_ok_nxt = (s1_byte_r == 8'd1);
                5'd3:    chan_ok_nxt = chan_ok_r && (s1_byte_r == 8'd0);
                5'd4:    rate_nxt[7:0]   = s1_byte_r;
                5'd5:    rate_nxt[15:8]  = s1_byte_r;
                5'd6:    rate_nxt[23:16] = s1_byte_r;
                5'd7:    rate_nxt[31:24] = s1_byte_r;
                5'd14:   bits_ok_nxt = (s1_byte_r == 8'd16);
                5'd15:   bits_ok_nxt = bits_ok_r && (s1_byte_r == 8'd0);
                default: fofs_nxt = fofs_r;
              endcase
              fofs_nxt = fofs_r + 5'd1;
            end
          end else if (kind_r == wavp_pkg::KIND_DATA) begin
            if (hold_vld_r) begin
              smp_push     = 1'b1;
              hold_vld_nxt = 1'b0;
            end else begin
              hold_vld_nxt = 1'b1;
              hold_nxt     = s1_byte_r;
            end
          end
          left_nxt = left_r - 32'd1;
          if ((left_r == 32'd1) && (kind_r == wavp_pkg::KIND_FMT)) begin
            if (small_r) begin
              err_nxt = wavp_pkg::ST_FMT_SMALL;
            end else begin
              have_fmt_nxt = 1'b1;
            end
            small_nxt = 1'b0;
          end
        end else if (pad_r) begin
          pad_nxt = 1'b0;
        end else if (hcnt_r == 3'd7) begin
          shift_nxt    = '0;
          hcnt_nxt     = 3'd0;
          left_nxt     = hdr_size;
          pad_nxt      = hdr_size[0];
          hold_vld_nxt = 1'b0;
          empty_body   = (hdr_size == 32'd0);
          if (hdr_id == wavp_pkg::ID_FMT) begin
            kind_nxt  = wavp_pkg::KIND_FMT;
            fofs_nxt  = 5'd0;
            small_nxt = (hdr_size < wavp_pkg::FMT_MIN_SIZE);
          end else if (hdr_id == wavp_pkg::ID_DATA) begin
            kind_nxt = wavp_pkg::KIND_DATA;
            if (dcnt_r != 2'd0) begin
              dcnt_nxt = 2'd2;
              err_nxt  = wavp_pkg::ST_TWO_DATA;
            end else begin
              dcnt_nxt = 2'd1;
              dlen_nxt = hdr_size;
            end
          end else begin
            kind_nxt = wavp_pkg::KIND_OTHER;
          end
          if (empty_body && (kind_nxt == wavp_pkg::KIND_FMT)) begin
            if (small_nxt) begin
              err_nxt = wavp_pkg::ST_FMT_SMALL;
            end else begin
              have_fmt_nxt = 1'b1;
            end
            small_nxt = 1'b0;
          end
        end else begin
          shift_nxt = shift_r | (56'(s1_byte_r) << {hcnt_r, 3'b000});
          hcnt_nxt  = hcnt_r + 3'd1;
        end
      end

      if (s1_fin_r) begin
        stat_push = 1'b1;
        priority if (hp_nxt < wavp_pkg::HDR_LEN) begin
          st = wavp_pkg::ST_SMALL;
        end else if (err_nxt != wavp_pkg::ST_OK) begin
          st = err_nxt;
        end else if (left_nxt != 32'd0) begin
          st = wavp_pkg::ST_OVERRUN;
        end else if (!have_fmt_nxt || (dcnt_nxt == 2'd0)) begin
          st = wavp_pkg::ST_MISSING;
        end else if (!fmt_ok_nxt) begin
          st = wavp_pkg::ST_NOT_PCM;
        end else if (!chan_ok_nxt) begin
          st = wavp_pkg::ST_NOT_MONO;
        end else if (!bits_ok_nxt) begin
          st = wavp_pkg::ST_NOT_16BIT;
        end else if ((rate_nxt == 32'd0) || rate_nxt[31]) begin
          st = wavp_pkg::ST_RATE;
        end else if ((dlen_nxt < 32'd2) || dlen_nxt[0]) begin
          st = wavp_pkg::ST_DATA_SIZE;
        end else begin
          st = wavp_pkg::ST_OK;
        end

        hp_nxt       = 4'd0;
        tag_bad_nxt  = 1'b0;
        shift_nxt    = '0;
        hcnt_nxt     = 3'd0;
        left_nxt     = 32'd0;
        kind_nxt     = wavp_pkg::KIND_OTHER;
        pad_nxt      = 1'b0;
        fofs_nxt     = 5'd0;
        rate_nxt     = 32'd0;
        fmt_ok_nxt   = 1'b0;
        chan_ok_nxt  = 1'b0;
        bits_ok_nxt  = 1'b0;
        small_nxt    = 1'b0;
        have_fmt_nxt = 1'b0;
        dcnt_nxt     = 2'd0;
        dlen_nxt     = 32'd0;
        hold_vld_nxt = 1'b0;
        hold_nxt     = 8'd0;
        err_nxt      = wavp_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_r       <= 4'd0;
      tag_bad_r  <= 1'b0;
      shift_r    <= '0;
      hcnt_r     <= 3'd0;
      left_r     <= 32'd0;
      kind_r     <= wavp_pkg::KIND_OTHER;
      pad_r      <= 1'b0;
      fofs_r     <= 5'd0;
      rate_r     <= 32'd0;
      fmt_ok_r   <= 1'b0;
      chan_ok_r  <= 1'b0;
      bits_ok_r  <= 1'b0;
      small_r    <= 1'b0;
      have_fmt_r <= 1'b0;
      dcnt_r     <= 2'd0;
      dlen_r     <= 32'd0;
      hold_vld_r <= 1'b0;
      hold_r     <= 8'd0;
      err_r      <= wavp_pkg::ST_OK;
    end else begin
      hp_r       <= hp_nxt;
      tag_bad_r  <= tag_bad_nxt;
      shift_r    <= shift_nxt;
      hcnt_r     <= hcnt_nxt;
      left_r     <= left_nxt;
      kind_r     <= kind_nxt;
      pad_r      <= pad_nxt;
      fofs_r     <= fofs_nxt;
      rate_r     <= rate_nxt;
      fmt_ok_r   <= fmt_ok_nxt;
      chan_ok_r  <= chan_ok_nxt;
      bits_ok_r  <= bits_ok_nxt;
      small_r    <= small_nxt;
      have_fmt_r <= have_fmt_nxt;
      dcnt_r     <= dcnt_nxt;
      dlen_r     <= dlen_nxt;
      hold_vld_r <= hold_vld_nxt;
      hold_r     <= hold_nxt;
      err_r      <= err_nxt;
    end
  end

  // An ok status cannot follow a byte that alters the rate, so the stored rate is current.
  always_comb begin
    smp_res            = '0;
    smp_res.kind       = wavp_pkg::RK_SAMPLE;
    smp_res.sample     = smp_val;
    smp_res.status     = wavp_pkg::ST_OK;
    stat_res           = '0;
    stat_res.kind      = wavp_pkg::RK_STATUS;
    stat_res.status    = st;
    stat_res.rate      = (st == wavp_pkg::ST_OK) ? rate_r[30:0] : 31'd0;
    stat_res.end_of_run = 1'b1;
  end

  assign pop       = out_valid && !out_stall;
  assign stat_addr = smp_push ? (wr_r + QPTR_W'(1)) : wr_r;
  assign wr_nxt    = wr_r + QPTR_W'(smp_push) + QPTR_W'(stat_push);
  assign rd_nxt    = rd_r + QPTR_W'(pop);
  assign qcnt_nxt  = qcnt_r + QCNT_W'(smp_push) + QCNT_W'(stat_push) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (smp_push) begin
      q_r[wr_r] <= smp_res;
    end
    if (stat_push) begin
      q_r[stat_addr] <= stat_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= '0;
      rd_r   <= '0;
      qcnt_r <= '0;
    end else begin
      wr_r   <= wr_nxt;
      rd_r   <= rd_nxt;
      qcnt_r <= qcnt_nxt;
    end
  end

  assign head             = q_r[rd_r];
  assign out_valid        = (qcnt_r != '0);
  assign out_result_kind  = head.kind;
  assign out_sample_value = head.sample;
  assign out_status_code  = head.status;
  assign out_sample_rate  = head.rate;
  assign out_end_of_run   = head.end_of_run;

  `WAVP_ASSERT_NOW(a_qcnt_bound, clk, rst_n, 1'b1, qcnt_r <= QCNT_W'(QDEPTH), "queue overfilled")
  `WAVP_ASSERT_NOW(a_status_shape, clk, rst_n, out_valid && (out_result_kind == wavp_pkg::RK_STATUS), out_end_of_run && (out_sample_value == 16'sd0), "malformed status word")
  `WAVP_ASSERT_NEXT(a_fin_resets, clk, rst_n, go && s1_fin_r, (hp_r == 4'd0) && (err_r == wavp_pkg::ST_OK), "parser not reset after final byte")
  `WAVP_ASSERT_NEXT(a_err_holds, clk, rst_n, !(go && s1_fin_r) && (err_r != wavp_pkg::ST_OK), err_r == $past(err_r), "latched error changed")

endmodule

`default_nettype wire
